// ===== sv/kat_pkg.sv =====
// ----------------------------------------------------------------------------
// kat_pkg
// Shared types and constants for the keyframe animation timer.
// ----------------------------------------------------------------------------
package kat_pkg;

    localparam int MaxKeys   = 8;
    localparam int KeyIdxW   = $clog2(MaxKeys);
    localparam int TimeW     = 32;
    localparam int TotalW    = TimeW + 16;
    localparam int FracSteps = 16;
    localparam int DivSteps  = TimeW + FracSteps;

    localparam logic [16:0]      OneQ16  = 17'h10000;
    localparam logic [TimeW-1:0] TimeMax = {TimeW{1'b1}};

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_START = 2'd1,
        OP_WRITE = 2'd2,
        OP_NONE  = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        REG_START_DELAY  = 3'd0,
        REG_ITER_LENGTH  = 3'd1,
        REG_REPEAT_COUNT = 3'd2,
        REG_DIRECTION    = 3'd3,
        REG_EASING       = 3'd4,
        REG_KEY_COUNT    = 3'd5
    } cfg_reg_t;

    typedef enum logic [1:0] {
        DIR_NORMAL      = 2'd0,
        DIR_REVERSE     = 2'd1,
        DIR_ALTERNATE   = 2'd2,
        DIR_ALT_REVERSE = 2'd3
    } dir_t;

    typedef enum logic [1:0] {
        EASE_LINEAR = 2'd0,
        EASE_IN     = 2'd1,
        EASE_OUT    = 2'd2,
        EASE_BOTH   = 2'd3
    } ease_t;

    typedef struct packed {
        logic [TimeW-1:0]  start_delay;
        logic [TimeW-1:0]  iteration_length;
        logic [15:0]       repeat_count;
        dir_t              direction;
        ease_t             easing;
        logic [3:0]        keyframe_count;
        logic [TotalW-1:0] total_len;
    } cfg_t;

    typedef struct packed {
        logic [16:0]        off;
        logic signed [31:0] val;
    } key_t;

    typedef struct packed {
        logic               is_write;
        logic [KeyIdxW-1:0] idx;
        key_t               key;
        logic [TimeW-1:0]   active;
        logic               done;
    } job_t;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_DIV,
        BK_DIR,
        BK_RD,
        BK_CHK,
        BK_FRAC,
        BK_FDIV,
        BK_EASE,
        BK_SHAPE,
        BK_MUL,
        BK_SUM,
        BK_OUT
    } back_state_t;

endpackage

// ===== sv/kat_if.sv =====
// ----------------------------------------------------------------------------
// kat interfaces
// Valid/ready channels for input words, frame words and config writes.
// ----------------------------------------------------------------------------
interface kat_item_if;
    logic               valid;
    logic               ready;
    logic [1:0]         opcode;
    logic [31:0]        time_delta;
    logic [2:0]         entry_index;
    logic [16:0]        entry_offset;
    logic signed [31:0] entry_value;

    modport source (output valid, opcode, time_delta, entry_index, entry_offset,
                    entry_value, input ready);
    modport sink   (input valid, opcode, time_delta, entry_index, entry_offset,
                    entry_value, output ready);
endinterface

interface kat_frame_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] frame_value;
    logic [16:0]        frame_progress;
    logic               finished;

    modport source (output valid, frame_value, frame_progress, finished, input ready);
    modport sink   (input valid, frame_value, frame_progress, finished, output ready);
endinterface

interface kat_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  reg_index;
    logic [31:0] wdata;

    modport source (output valid, reg_index, wdata, input ready);
    modport sink   (input valid, reg_index, wdata, output ready);
endinterface

// ===== sv/kat_queue.sv =====
// ----------------------------------------------------------------------------
// kat_queue
// Two-entry job queue between the front and back parts.
// ----------------------------------------------------------------------------
module kat_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  kat_pkg::job_t push_job,
    output logic          full,
    input  logic          pop,
    output logic          empty,
    output kat_pkg::job_t head
);
    import kat_pkg::*;

    job_t       slot_mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign head  = slot_mem[rd_ptr_reg];

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_mem[wr_ptr_reg] <= push_job;
        end
    end
endmodule

// ===== sv/kat_front.sv =====
// ----------------------------------------------------------------------------
// kat_front
// Accepts input words, keeps elapsed time and run state, queues jobs.
// ----------------------------------------------------------------------------
module kat_front (
    input  logic          clk,
    input  logic          rst_n,
    kat_item_if.sink      item,
    input  kat_pkg::cfg_t cfg,
    input  logic          q_full,
    output logic          q_push,
    output kat_pkg::job_t q_job
);
    import kat_pkg::*;

    logic [TimeW-1:0] elapsed_reg, elapsed_next;
    logic             running_reg, running_next;

    logic             accept;
    logic [TimeW-1:0] sum_sat;
    logic [TimeW-1:0] active;
    logic             past_delay;
    logic             done;
    logic             tick_go;

    assign item.ready = !q_full;
    assign accept     = item.valid && item.ready;

    // saturating time update and classification
    always_comb
    begin
        sum_sat    = (item.time_delta >= (TimeMax - elapsed_reg)) ? TimeMax
                                                                   : elapsed_reg + item.time_delta;
        past_delay = (sum_sat >= cfg.start_delay);
        active     = sum_sat - cfg.start_delay;
        done       = (cfg.repeat_count != 16'd0) && ({16'd0, active} >= cfg.total_len);
        tick_go    = accept && (item.opcode == OP_TICK) && running_reg;
    end

    // job to the back part
    always_comb
    begin
        q_push       = (accept && (item.opcode == OP_WRITE)) || (tick_go && past_delay);
        q_job.is_write = (item.opcode == OP_WRITE);
        q_job.idx      = item.entry_index;
        q_job.key.off  = item.entry_offset;
        q_job.key.val  = item.entry_value;
        q_job.active   = active;
        q_job.done     = done;
    end

    // run state
    always_comb
    begin
        elapsed_next = elapsed_reg;
        running_next = running_reg;
        if (accept && (item.opcode == OP_START))
        begin
            elapsed_next = '0;
            running_next = 1'b1;
        end
        else if (tick_go)
        begin
            elapsed_next = sum_sat;
            if (past_delay && done)
            begin
                running_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elapsed_reg <= '0;
            running_reg <= 1'b0;
        end
        else
        begin
            elapsed_reg <= elapsed_next;
            running_reg <= running_next;
        end
    end
endmodule

// ===== sv/kat_back.sv =====
// ----------------------------------------------------------------------------
// kat_back
// Executes jobs: keyframe writes; for ticks, progress divide, direction, segment search, easing, lerp.
// ----------------------------------------------------------------------------
module kat_back (
    input  logic          clk,
    input  logic          rst_n,
    input  kat_pkg::cfg_t cfg,
    input  logic          job_valid,
    input  kat_pkg::job_t job,
    output logic          job_pop,
    kat_frame_if.source   frame
);
    import kat_pkg::*;

    back_state_t state_reg, state_next;

    key_t             key_mem [MaxKeys];
    key_t             key_rd_reg;

    logic [TimeW-1:0] rem_reg;
    logic [TimeW-1:0] dvd_reg;
    logic [16:0]      quo_reg;
    logic [5:0]       cnt_reg;
    logic [16:0]      p_reg;
    logic             iter_reg;
    logic             done_reg;
    logic [KeyIdxW-1:0] idx_reg;
    key_t             first_reg, prev_reg, from_reg, to_reg;
    logic [16:0]      frem_reg, fden_reg;
    logic [16:0]      t_reg;
    logic [35:0]      prod_reg;
    logic             hi_half_reg;
    logic [16:0]      e_reg;
    logic signed [50:0] mul_reg;
    logic signed [31:0] val_reg;

    logic               out_valid_reg;
    logic signed [31:0] out_value_reg;
    logic [16:0]        out_prog_reg;
    logic               out_fin_reg;

    // derived signals
    logic [3:0]         n_keys;
    logic [TimeW:0]     div_r;
    logic               div_ge;
    logic [16:0]        quo_step;
    logic               flip;
    logic               last_idx;
    logic               in_seg;
    logic signed [17:0] num, den;
    logic [16:0]        an, ad;
    logic               frac_zero;
    logic [17:0]        fdiv_r;
    logic               fdiv_ge;
    logic [18:0]        ease_m;
    logic signed [32:0] diff;
    logic               out_free;

    assign n_keys  = (cfg.keyframe_count > 4'(MaxKeys)) ? 4'(MaxKeys) : cfg.keyframe_count;
    assign job_pop = (state_reg == BK_IDLE) && job_valid;
    assign out_free = !out_valid_reg || frame.ready;

    // datapath helpers
    always_comb
    begin
        div_r    = {rem_reg, dvd_reg[TimeW-1]};
        div_ge   = (div_r >= {1'b0, cfg.iteration_length});
        quo_step = {quo_reg[15:0], div_ge};

        unique case (cfg.direction)
            DIR_NORMAL:      flip = 1'b0;
            DIR_REVERSE:     flip = 1'b1;
            DIR_ALTERNATE:   flip = iter_reg;
            DIR_ALT_REVERSE: flip = !iter_reg;
            default:         flip = 1'b0;
        endcase

        last_idx = ({1'b0, idx_reg} == (n_keys - 4'd1));
        in_seg   = (prev_reg.off <= p_reg) && (p_reg <= key_rd_reg.off);

        num = $signed({1'b0, p_reg}) - $signed({1'b0, from_reg.off});
        den = $signed({1'b0, to_reg.off}) - $signed({1'b0, from_reg.off});
        an  = num[17] ? 17'(-num) : num[16:0];
        ad  = den[17] ? 17'(-den) : den[16:0];
        frac_zero = (den == 18'sd0) || (num == 18'sd0) || (num[17] != den[17]);

        fdiv_r  = {frem_reg, 1'b0};
        fdiv_ge = (fdiv_r >= {1'b0, fden_reg});

        unique case (cfg.easing)
            EASE_LINEAR: ease_m = 19'(OneQ16);
            EASE_IN:     ease_m = {2'b0, t_reg};
            EASE_OUT:    ease_m = 19'(2 * OneQ16) - {2'b0, t_reg};
            EASE_BOTH:   ease_m = (t_reg < 17'(OneQ16 / 2)) ? {1'b0, t_reg, 1'b0}
                                  : 19'(4 * OneQ16) - {1'b0, t_reg, 1'b0};
            default:     ease_m = 19'(OneQ16);
        endcase

        diff = $signed({to_reg.val[31], to_reg.val}) - $signed({from_reg.val[31], from_reg.val});
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (job_valid && !job.is_write)
                begin
                    if (job.done || (cfg.iteration_length == '0))
                        state_next = BK_DIR;
                    else
                        state_next = BK_DIV;
                end
            end
            BK_DIV:   if (cnt_reg == 6'd0) state_next = BK_DIR;
            BK_DIR:   state_next = (n_keys == 4'd0) ? BK_OUT : BK_RD;
            BK_RD:    state_next = BK_CHK;
            BK_CHK:
            begin
                if (idx_reg == '0)
                    state_next = (n_keys == 4'd1) ? BK_FRAC : BK_RD;
                else if (in_seg || last_idx)
                    state_next = BK_FRAC;
                else
                    state_next = BK_RD;
            end
            BK_FRAC:  state_next = (frac_zero || an >= ad) ? BK_EASE : BK_FDIV;
            BK_FDIV:  if (cnt_reg == 6'd0) state_next = BK_EASE;
            BK_EASE:  state_next = BK_SHAPE;
            BK_SHAPE: state_next = BK_MUL;
            BK_MUL:   state_next = BK_SUM;
            BK_SUM:   state_next = BK_OUT;
            BK_OUT:   if (out_free) state_next = BK_IDLE;
            default:  state_next = BK_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= BK_IDLE;
        else
            state_reg <= state_next;
    end

    // keyframe store
    always_ff @(posedge clk)
    begin
        if (job_pop && job.is_write)
            key_mem[job.idx] <= job.key;
        if (state_reg == BK_RD)
            key_rd_reg <= key_mem[idx_reg];
    end

    // working registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            BK_IDLE:
            begin
                done_reg <= job.done;
                dvd_reg  <= job.active;
                rem_reg  <= '0;
                quo_reg  <= '0;
                cnt_reg  <= 6'(DivSteps - 1);
                p_reg    <= OneQ16;
                iter_reg <= 1'b0;
                idx_reg  <= '0;
            end
            BK_DIV:
            begin
                rem_reg <= div_ge ? TimeW'(div_r - {1'b0, cfg.iteration_length})
                                  : div_r[TimeW-1:0];
                dvd_reg <= {dvd_reg[TimeW-2:0], 1'b0};
                quo_reg <= quo_step;
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd0)
                begin
                    p_reg    <= {1'b0, quo_step[15:0]};
                    iter_reg <= quo_step[16];
                end
            end
            BK_DIR:
            begin
                if (!done_reg && flip)
                    p_reg <= OneQ16 - p_reg;
                val_reg <= '0;
            end
            BK_RD:
            begin
            end
            BK_CHK:
            begin
                prev_reg <= key_rd_reg;
                idx_reg  <= idx_reg + 1'b1;
                if (idx_reg == '0)
                begin
                    first_reg <= key_rd_reg;
                    from_reg  <= key_rd_reg;
                    to_reg    <= key_rd_reg;
                end
                else if (in_seg)
                begin
                    from_reg <= prev_reg;
                    to_reg   <= key_rd_reg;
                end
                else
                begin
                    from_reg <= first_reg;
                    to_reg   <= key_rd_reg;
                end
            end
            BK_FRAC:
            begin
                frem_reg <= an;
                fden_reg <= ad;
                cnt_reg  <= 6'(FracSteps - 1);
                if (frac_zero)
                    t_reg <= '0;
                else if (an >= ad)
                    t_reg <= OneQ16;
                else
                    t_reg <= '0;
            end
            BK_FDIV:
            begin
                frem_reg <= fdiv_ge ? 17'(fdiv_r - {1'b0, fden_reg}) : fdiv_r[16:0];
                t_reg    <= {t_reg[15:0], fdiv_ge};
                cnt_reg  <= cnt_reg - 6'd1;
            end
            BK_EASE:
            begin
                prod_reg    <= t_reg * ease_m;
                hi_half_reg <= (cfg.easing == EASE_BOTH) && (t_reg >= 17'(OneQ16 / 2));
            end
            BK_SHAPE:
            begin
                if (t_reg == '0)
                    e_reg <= '0;
                else if (t_reg >= OneQ16)
                    e_reg <= OneQ16;
                else if (hi_half_reg)
                    e_reg <= 17'(prod_reg[35:16] - 20'(OneQ16));
                else
                    e_reg <= prod_reg[32:16];
            end
            BK_MUL:
            begin
                mul_reg <= diff * $signed({1'b0, e_reg});
            end
            BK_SUM:
            begin
                val_reg <= from_reg.val + $signed(mul_reg[47:16]);
            end
            BK_OUT:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (state_reg == BK_OUT && out_free)
            out_valid_reg <= 1'b1;
        else if (frame.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == BK_OUT && out_free)
        begin
            out_value_reg <= val_reg;
            out_prog_reg  <= p_reg;
            out_fin_reg   <= done_reg;
        end
    end

    assign frame.valid          = out_valid_reg;
    assign frame.frame_value    = out_value_reg;
    assign frame.frame_progress = out_prog_reg;
    assign frame.finished       = out_fin_reg;
endmodule

// ===== sv/keyframe_animation_timer.sv =====
// A tick job runs the back part's 48-step progress divider (skipped for a finished run or
// a zero iteration length), a keyframe-by-keyframe segment search and, for a fraction in
// (0, 1), a 16-step fraction divider; no new job starts until the frame is registered.
// Write, start and idle words are taken one per cycle while the job queue has room.
// Reset clears run state, elapsed time and config to defaults; keyframes are not cleared.
// ----------------------------------------------------------------------------
// keyframe_animation_timer
// Top level: config registers, front part, job queue and back part.
// ----------------------------------------------------------------------------
module keyframe_animation_timer (
    input  logic        clk,
    input  logic        rst_n,
    kat_item_if.sink    item,
    kat_frame_if.source frame,
    kat_cfg_if.sink     cfg
);
    import kat_pkg::*;

    cfg_t cfg_reg;
    logic q_push, q_full, q_pop, q_empty;
    job_t q_in, q_head;

    assign cfg.ready = 1'b1;

    // config register file, total run length kept as a 32 by 16 product
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_delay      <= '0;
            cfg_reg.iteration_length <= '0;
            cfg_reg.repeat_count     <= 16'd1;
            cfg_reg.direction        <= DIR_NORMAL;
            cfg_reg.easing           <= EASE_BOTH;
            cfg_reg.keyframe_count   <= 4'd0;
            cfg_reg.total_len        <= '0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.reg_index)
                REG_START_DELAY:  cfg_reg.start_delay      <= cfg.wdata;
                REG_ITER_LENGTH:
                begin
                    cfg_reg.iteration_length <= cfg.wdata;
                    cfg_reg.total_len        <= TotalW'(cfg.wdata)
                                                * TotalW'(cfg_reg.repeat_count);
                end
                REG_REPEAT_COUNT:
                begin
                    cfg_reg.repeat_count <= cfg.wdata[15:0];
                    cfg_reg.total_len    <= TotalW'(cfg_reg.iteration_length)
                                            * TotalW'(cfg.wdata[15:0]);
                end
                REG_DIRECTION:    cfg_reg.direction        <= dir_t'(cfg.wdata[1:0]);
                REG_EASING:       cfg_reg.easing           <= ease_t'(cfg.wdata[1:0]);
                REG_KEY_COUNT:    cfg_reg.keyframe_count   <= cfg.wdata[3:0];
                default:
                begin
                end
            endcase
        end
    end

    kat_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cfg    (cfg_reg),
        .q_full (q_full),
        .q_push (q_push),
        .q_job  (q_in)
    );

    kat_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (q_in),
        .full     (q_full),
        .pop      (q_pop),
        .empty    (q_empty),
        .head     (q_head)
    );

    kat_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .job_valid (!q_empty),
        .job       (q_head),
        .job_pop   (q_pop),
        .frame     (frame)
    );

    // checks
    a_final_at_one: assert property (@(posedge clk) disable iff (!rst_n)
        frame.valid && frame.finished |-> frame.frame_progress == OneQ16)
        else $error("final frame progress not one");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_push && q_full))
        else $error("job queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_pop && q_empty))
        else $error("job queue underflow");
endmodule
